>>> rtl/agsr_pkg.sv
// Package for the audio gain and speed resampler: register indexes, states, Q-format constants.
`timescale 1ns / 1ps

package agsr_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_GAIN          = 2'd0,
        REG_SPEED         = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } reg_index_t;

    // Control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_MARK
    } agsr_state_t;

    // Q2.14 one, and the register ranges
    localparam logic [15:0] ONE_Q14    = 16'd16384;
    localparam logic [15:0] GAIN_MAX   = 16'd32768;
    localparam logic [15:0] GAIN_RESET = 16'd32768;
    localparam logic [15:0] SPEED_MIN  = 16'd8192;
    localparam logic [15:0] SPEED_MAX  = 16'd32768;
    localparam logic [15:0] SPEED_RESET = 16'd16384;

endpackage

>>> rtl/audio_gain_speed_resampler_unit.sv
// Audio gain and speed resampler: scales samples, buffers one frame, emits nearest-neighbor copies.
`timescale 1ns / 1ps

// Interleaved PCM samples enter on the s_ side, one per word, chunk end on s_tlast.
// Each sample is scaled by the Q1.15 gain (floored) and written to a one-frame
// memory. When a frame is complete it is read back zero, one or two times (speed
// 0.5..2.0 in Q2.14), one memory read per output word; the last copy of a chunk
// carries m_tlast, and a chunk whose last frame yields no copy ends in a single
// marker word with m_tuser low. Timing: while idle an input word is taken as soon as it
// is valid; a word that completes a frame then holds the input while each copy is read,
// one word at a time (the single read port of the frame memory sets this), or until the
// marker is sent after draining. Output stalls hold the input longer. The frame memory
// has no reset; registers reset to gain 1.0, speed 1.0, two channels.
module audio_gain_speed_resampler_unit
    import agsr_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [15:0]            cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,   // sample_in
    input  logic                   s_tlast,   // chunk_last
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((SAMPLE_BITS + 10) / 8) * 8 - 1:0] m_tdata,   // sample_out, channel_index
    output logic                   m_tuser,   // sample_valid
    output logic                   m_tlast    // chunk_end
);

    localparam int MDW = SAMPLE_BITS + 3;
    localparam int MTW = ((MDW + 7) / 8) * 8;
    localparam int AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PW  = SAMPLE_BITS + 17;
    localparam logic [4:0] CH_MAX   = 5'(MAX_CHANNELS > 15 ? 15 : MAX_CHANNELS);
    localparam logic [3:0] CH_RESET = 4'(MAX_CHANNELS < 2 ? MAX_CHANNELS : 2);

    // configuration registers
    logic [15:0] gain_reg;
    logic [15:0] speed_reg;
    logic [3:0]  count_reg;

    // control state
    agsr_state_t state_reg, state_next;
    logic [2:0]  cp_reg, cp_next;
    logic [15:0] phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;

    // read data stage
    logic                   rd_valid_reg, rd_valid_next;
    logic [SAMPLE_BITS-1:0] rd_sample_reg;
    logic [2:0]             rd_ch_reg;
    logic                   rd_end_reg;
    logic                   rd_end_next;
    logic                   rd_en;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic [2:0]             out_ch_reg, out_ch_next;
    logic                   out_flag_reg, out_flag_next;
    logic                   out_end_reg, out_end_next;

    // frame memory
    logic [SAMPLE_BITS-1:0] frame_mem [MAX_CHANNELS];

    logic                   s_accept;
    logic                   out_free;
    logic                   load_rd;
    logic                   frame_done;
    logic [15:0]            phase_adv;
    logic                   copy_end;
    logic                   more_adv;
    logic signed [PW-1:0]   product;
    logic [SAMPLE_BITS-1:0] scaled;
    logic                   wr_en;

    // another copy is allowed at this position; on the last frame it must round in
    function automatic logic more_copy(input logic [15:0] ph, input logic [15:0] spd,
                                       input logic lst);
        logic [16:0] twice;
        begin
            twice = {ph, 1'b0} + {1'b0, spd};
            more_copy = (ph < ONE_Q14) && (!lst || (twice <= {ONE_Q14, 1'b0}));
        end
    endfunction

    // gain scaling, floored
    assign product = $signed(s_tdata[SAMPLE_BITS-1:0]) * $signed({1'b0, gain_reg});
    assign scaled  = product[SAMPLE_BITS+14:15];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign load_rd  = rd_valid_reg && out_free;
    assign rd_en    = (state_reg == ST_EMIT) && (!rd_valid_reg || load_rd);
    assign wr_en    = s_accept && ({1'b0, cp_reg} < 4'(MAX_CHANNELS > 15 ? 15 : MAX_CHANNELS)
                                   || MAX_CHANNELS > 8);

    assign frame_done = ({1'b0, cp_reg} + 4'd1) >= count_reg;
    assign phase_adv  = phase_reg + speed_reg;
    assign copy_end   = (cnt_reg + 4'd1) == count_reg;
    assign more_adv   = more_copy(phase_adv, speed_reg, last_reg);

    // configuration writes, saturated to range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_RESET;
            speed_reg <= SPEED_RESET;
            count_reg <= CH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GAIN: begin
                    gain_reg <= (cfg_wdata > GAIN_MAX) ? GAIN_MAX : cfg_wdata;
                end
                REG_SPEED: begin
                    if (cfg_wdata < SPEED_MIN) begin
                        speed_reg <= SPEED_MIN;
                    end else if (cfg_wdata > SPEED_MAX) begin
                        speed_reg <= SPEED_MAX;
                    end else begin
                        speed_reg <= cfg_wdata;
                    end
                end
                REG_CHANNEL_COUNT: begin
                    if (cfg_wdata[3:0] == 4'd0) begin
                        count_reg <= 4'd1;
                    end else if ({1'b0, cfg_wdata[3:0]} > CH_MAX) begin
                        count_reg <= CH_MAX[3:0];
                    end else begin
                        count_reg <= cfg_wdata[3:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // frame memory: write on accept, registered read while emitting
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[AW'(cp_reg)] <= scaled;
        end
        if (rd_en) begin
            rd_sample_reg <= frame_mem[AW'(cnt_reg)];
            rd_ch_reg     <= cnt_reg[2:0];
            rd_end_reg    <= rd_end_next;
        end
    end

    // next state and outputs
    always_comb begin
        state_next      = state_reg;
        cp_next         = cp_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        rd_valid_next   = rd_valid_reg;
        rd_end_next     = 1'b0;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_ch_next     = out_ch_reg;
        out_flag_next   = out_flag_reg;
        out_end_next    = out_end_reg;

        // read stage into the output register
        if (load_rd) begin
            rd_valid_next   = 1'b0;
            out_valid_next  = 1'b1;
            out_sample_next = rd_sample_reg;
            out_ch_next     = rd_ch_reg;
            out_flag_next   = 1'b1;
            out_end_next    = rd_end_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (frame_done && more_copy(phase_reg, speed_reg, s_tlast)) begin
                        state_next = ST_EMIT;
                        cnt_next   = 4'd0;
                        last_next  = s_tlast;
                        cp_next    = 3'd0;
                    end else if (s_tlast) begin
                        state_next = ST_MARK;
                        phase_next = 16'd0;
                        cp_next    = 3'd0;
                    end else if (frame_done) begin
                        phase_next = (phase_reg >= ONE_Q14) ? phase_reg - ONE_Q14 : 16'd0;
                        cp_next    = 3'd0;
                    end else begin
                        cp_next = cp_reg + 3'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (rd_en) begin
                    rd_valid_next = 1'b1;
                    if (copy_end) begin
                        phase_next = phase_adv;
                        if (more_adv) begin
                            cnt_next = 4'd0;
                        end else begin
                            rd_end_next = last_reg;
                            state_next  = ST_IDLE;
                            if (last_reg || phase_adv < ONE_Q14) begin
                                phase_next = 16'd0;
                            end else begin
                                phase_next = phase_adv - ONE_Q14;
                            end
                        end
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            ST_MARK: begin
                // end marker after any pending sample word
                if (!rd_valid_reg && out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = '0;
                    out_ch_next     = 3'd0;
                    out_flag_next   = 1'b0;
                    out_end_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cp_reg        <= 3'd0;
            phase_reg     <= 16'd0;
            cnt_reg       <= 4'd0;
            last_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cp_reg        <= cp_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        out_sample_reg <= out_sample_next;
        out_ch_reg     <= out_ch_next;
        out_flag_reg   <= out_flag_next;
        out_end_reg    <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MTW'({out_ch_reg, out_sample_reg});
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_end_reg;

endmodule

>>> tb/tb_audio_gain_speed_resampler_unit.sv
// Self-checking testbench for the audio gain and speed resampler, with a built-in predictor.
`timescale 1ns / 1ps

module tb_audio_gain_speed_resampler_unit
    import agsr_pkg::*;
;

    localparam int MAX_CH       = 8;
    localparam int Q14_ONE      = int'(ONE_Q14);
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 60;

    // one input word: scaled sample source plus chunk end flag
    typedef struct packed {
        logic        chunk_last;
        logic [15:0] pcm;
    } in_word_t;

    // one expected output word
    typedef struct packed {
        logic        chunk_end;
        logic        sample_valid;
        logic [2:0]  channel;
        logic [15:0] pcm;
    } out_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // sample_in
    logic        s_tlast = 1'b0; // chunk_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // sample_out, channel_index, zero pad
    logic        m_tuser;        // sample_valid
    logic        m_tlast;        // chunk_end

    // stimulus and scoreboard
    in_word_t  sample_queue[$];
    out_word_t expected_words[$];
    in_word_t  drv_word;
    logic      word_taken = 1'b0;
    int        idle_pct = 37;
    int        cycle_count = 0;
    int        queued_count = 0;
    int        accepted_count = 0;
    int        out_count = 0;
    int        mismatch_count = 0;
    int        settings_count = 0;

    // predictor copy of registers and state
    int          gain_q15 = 32768;
    int          speed_q14 = 16384;
    int          chan_count = 2;
    logic [15:0] frame_mirror [MAX_CH];
    int          chan_pos = 0;
    int          out_phase = 0;

    audio_gain_speed_resampler_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Scale one sample into the frame; on frame completion emit nearest-neighbor copies
    function automatic void predict_resample(logic [15:0] din, logic chunk_last);
        int        scaled;
        int        n;
        int        c;
        out_word_t w;
        scaled = (int'($signed(din)) * gain_q15) >>> 15;
        n = 0;
        frame_mirror[chan_pos] = scaled[15:0];
        if (chan_pos + 1 >= chan_count) begin
            while (out_phase < Q14_ONE &&
                   (!chunk_last || 2 * out_phase + speed_q14 <= 2 * Q14_ONE) &&
                   n + chan_count <= 2 * MAX_CH) begin
                for (c = 0; c < chan_count; c++) begin
                    w.pcm = frame_mirror[c];
                    w.channel = c[2:0];
                    w.sample_valid = 1'b1;
                    w.chunk_end = 1'b0;
                    expected_words.push_back(w);
                    n++;
                end
                out_phase += speed_q14;
            end
            out_phase = (out_phase >= Q14_ONE) ? out_phase - Q14_ONE : 0;
            chan_pos = 0;
        end else begin
            chan_pos = (chan_pos + 1) & 7;
        end
        if (chunk_last) begin
            // no copy on the last frame: a lone end marker
            if (n == 0) begin
                w = '0;
                w.chunk_end = 1'b1;
            end else begin
                w = expected_words.pop_back();
                w.chunk_end = 1'b1;
            end
            expected_words.push_back(w);
            out_phase = 0;
            chan_pos = 0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("[cycle %0d] %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Compare one accepted output word with the oldest expectation
    task automatic check_word();
        out_word_t want;
        out_count++;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected output word %h", m_tdata));
        end else begin
            want = expected_words.pop_front();
            if (m_tdata[15:0] !== want.pcm)
                report_mismatch($sformatf("sample_out %h, want %h", m_tdata[15:0], want.pcm));
            if (m_tdata[18:16] !== want.channel)
                report_mismatch($sformatf("channel_index %0d, want %0d",
                                          m_tdata[18:16], want.channel));
            if (m_tuser !== want.sample_valid)
                report_mismatch($sformatf("sample_valid %b, want %b", m_tuser,
                                          want.sample_valid));
            if (m_tlast !== want.chunk_end)
                report_mismatch($sformatf("chunk_end %b, want %b", m_tlast, want.chunk_end));
        end
    endtask

    // Monitor: input acceptance feeds the predictor, output words are checked
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run timed out with %0d words still expected", expected_words.size());
            $display("Mismatches found");
            $finish;
        end else begin
            word_taken = aresetn && s_tvalid && s_tready;
            if (word_taken) begin
                predict_resample(s_tdata, s_tlast);
                accepted_count++;
            end
            if (aresetn && m_tvalid && m_tready)
                check_word();
        end
    end

    // Input driver: holds a word until taken, idles at random between words
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (sample_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                drv_word = sample_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= drv_word.pcm;
                s_tlast <= drv_word.chunk_last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= idle_pct);
    end

    task automatic add_word(logic [15:0] pcm, logic chunk_last);
        in_word_t w;
        w.pcm = pcm;
        w.chunk_last = chunk_last;
        sample_queue.push_back(w);
        queued_count++;
    endtask

    // Register write; the mirror saturates just as the block should
    task automatic set_reg(reg_index_t idx, logic [15:0] value);
        int v;
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAIN: begin
                v = int'(value);
                gain_q15 = (v > int'(GAIN_MAX)) ? int'(GAIN_MAX) : v;
            end
            REG_SPEED: begin
                v = int'(value);
                if (v < int'(SPEED_MIN)) v = int'(SPEED_MIN);
                if (v > int'(SPEED_MAX)) v = int'(SPEED_MAX);
                speed_q14 = v;
            end
            REG_CHANNEL_COUNT: begin
                v = int'(value[3:0]);
                if (v < 1) v = 1;
                if (v > MAX_CH) v = MAX_CH;
                chan_count = v;
            end
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [15:0] g, logic [15:0] sp, logic [15:0] cc);
        set_reg(REG_GAIN, g);
        set_reg(REG_SPEED, sp);
        set_reg(REG_CHANNEL_COUNT, cc);
        settings_count++;
    endtask

    // Wait until every word is taken and every result has come, then let the block settle
    task automatic drain();
        do @(negedge aclk);
        while (!(accepted_count == queued_count && expected_words.size() == 0));
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Samples lean toward the extremes now and then
    function automatic logic [15:0] pick_pcm();
        logic [15:0] r;
        r = 16'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: r = 16'h8000;
                1: r = 16'h7FFF;
                2: r = 16'h0000;
                default: r = 16'hFFFF;
            endcase
        end
        return r;
    endfunction

    // Random chunks: mostly whole frames ending on tlast, some partial, some ragged
    task automatic random_chunks(int words);
        int fed;
        int kind;
        int total;
        int frames;
        int extra;
        int i;
        fed = 0;
        while (fed < words) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                frames = $urandom_range(1, 3);
                total = frames * chan_count;
            end else if (kind == 7) begin
                frames = $urandom_range(0, 2);
                extra = (chan_count > 1) ? $urandom_range(1, chan_count - 1) : 0;
                total = frames * chan_count + extra;
                if (total == 0) total = 1;
            end else if (kind == 8) begin
                total = $urandom_range(1, 2 * chan_count + 1);
            end else begin
                total = $urandom_range(1, 2 * chan_count);
            end
            for (i = 0; i < total; i++)
                add_word(pick_pcm(), (kind != 9) && (i == total - 1));
            fed += total;
        end
    endtask

    initial begin
        logic [15:0] g;
        logic [15:0] sp;
        logic [15:0] cc;
        int p;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_GAIN;
        cfg_wdata = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: full-scale and near-zero samples, then a partial frame closing a chunk
        add_word(16'h8000, 1'b0);
        add_word(16'h7FFF, 1'b0);
        add_word(16'h0000, 1'b0);
        add_word(16'hFFFF, 1'b1);
        add_word(16'h0005, 1'b1);
        drain();

        // out-of-range writes saturate: unity gain, half speed, one channel
        apply_setting(16'hFFFF, 16'h0000, 16'h0000);
        add_word(16'h7FFF, 1'b1);
        add_word(16'h8000, 1'b1);
        drain();

        // zero gain, speed saturates to 2.0, channel count from the low nibble
        apply_setting(16'h0000, 16'hFFFF, 16'h0013);
        add_word(16'h7FFF, 1'b0);
        add_word(16'h8000, 1'b0);
        add_word(16'h1234, 1'b1);
        drain();

        // half gain floors negative products; last frame at 2.0 gives an end marker
        apply_setting(16'h4000, SPEED_MAX, 16'h0001);
        add_word(16'hFFFD, 1'b0);
        add_word(16'h0007, 1'b1);
        drain();

        // channel count lowered in mid-frame
        apply_setting(16'h4000, SPEED_RESET, 16'h0004);
        add_word(16'd100, 1'b0);
        add_word(-16'sd100, 1'b0);
        drain();
        set_reg(REG_CHANNEL_COUNT, 16'h0001);
        add_word(16'd300, 1'b1);
        drain();

        // channel count raised in mid-frame
        set_reg(REG_CHANNEL_COUNT, 16'h0002);
        add_word(16'd1, 1'b0);
        drain();
        set_reg(REG_CHANNEL_COUNT, 16'h0003);
        add_word(16'd2, 1'b0);
        add_word(16'd3, 1'b1);
        drain();

        // random phases, the extremes first, one phase without idling
        for (p = 0; p < 8; p++) begin
            if (p == 0) begin
                g = GAIN_MAX;
                sp = SPEED_MIN;
                cc = 16'd8;
            end else if (p == 1) begin
                g = 16'd1;
                sp = SPEED_MAX;
                cc = 16'd1;
            end else begin
                case ($urandom_range(0, 3))
                    0: g = 16'd0;
                    1: g = GAIN_MAX;
                    2: g = 16'($urandom_range(0, 32768));
                    default: g = 16'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: sp = SPEED_MIN;
                    1: sp = SPEED_MAX;
                    2: sp = 16'($urandom_range(8192, 32768));
                    default: sp = 16'($urandom);
                endcase
                case ($urandom_range(0, 2))
                    0: cc = 16'($urandom_range(0, 15));
                    1: cc = {12'($urandom_range(0, 4095)), 4'($urandom_range(1, 8))};
                    default: cc = 16'($urandom_range(1, 8));
                endcase
            end
            idle_pct = (p == 3) ? 0 : 37;
            apply_setting(g, sp, cc);
            random_chunks(PHASE_WORDS);
            drain();
        end

        $display("Sent %0d input words, checked %0d output words", accepted_count, out_count);
        $display("Register settings applied: %0d", settings_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/agsr_pkg.sv
rtl/audio_gain_speed_resampler_unit.sv
tb/tb_audio_gain_speed_resampler_unit.sv
